@@ rtl/assert_macros.svh @@
// Assertion macros shared by the VIN check digit validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define VCDV_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define VCDV_NEVER(lbl, clk_i, rst_n_i, expr, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) !(expr)) else $error(msg);

`endif

@@ rtl/vcdv_pkg.sv @@
// Types, constants and helper functions of the VIN check digit validator.
`default_nettype none

package vcdv_pkg;

	localparam int unsigned VCDV_VIN_LEN       = 17;
	localparam int unsigned VCDV_CHECK_POS     = 8;
	localparam int unsigned VCDV_MODULUS       = 11;
	localparam int unsigned VCDV_RECIP         = 187;  // ceil(2^11 / 11)
	localparam int unsigned VCDV_RECIP_SHIFT   = 11;
	localparam int unsigned VCDV_QUEUE_DEPTH   = 2;
	localparam logic [7:0]  VCDV_CHECK_X       = 8'h58;  // 'X'
	localparam logic [7:0]  VCDV_DIGIT_ZERO    = 8'h30;  // '0'
	localparam logic [7:0]  VCDV_FIRST_CHAR_RST = 8'h4C; // 'L'

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_FIRST = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR  = 2'd2;
	localparam logic [1:0] ST_MISMATCH  = 2'd3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_req;
	} vcdv_in_t;

	typedef struct packed {
		logic       valid_res;
		logic [1:0] status;
		logic [7:0] expected_check;
	} vcdv_out_t;

	// One classified character as it waits between front and back.
	typedef struct packed {
		logic       first;
		logic       bad_first;
		logic       bad_char;
		logic [6:0] prod;
		logic       is_check;
		logic       is_last;
		logic [7:0] char_code;
	} vcdv_ent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} vcdv_qstat_t;

	// Returns {invalid, value}; value is zero for an invalid byte.
	function automatic logic [4:0] vcdv_translit(input logic [7:0] c);
		logic [4:0] r;
		r = {1'b1, 4'd0};
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c inside {8'h4F, 8'h51}) begin
			// O and Q sit inside the J-R range but are never allowed
			r = {1'b1, 4'd0};
		end else if (c inside {[8'h41:8'h48]}) begin
			r = {1'b0, 4'(c - 8'h40)};
		end else if (c inside {[8'h4A:8'h52]}) begin
			r = {1'b0, 4'(c - 8'h49)};
		end else if (c inside {[8'h53:8'h5A]}) begin
			r = {1'b0, 4'(c - 8'h51)};
		end
		return r;
	endfunction

	function automatic logic [3:0] vcdv_weight(input logic [4:0] pos);
		logic [3:0] w;
		case (pos)
			5'd0:    w = 4'd8;
			5'd1:    w = 4'd7;
			5'd2:    w = 4'd6;
			5'd3:    w = 4'd5;
			5'd4:    w = 4'd4;
			5'd5:    w = 4'd3;
			5'd6:    w = 4'd2;
			5'd7:    w = 4'd10;
			5'd8:    w = 4'd0;
			5'd9:    w = 4'd9;
			5'd10:   w = 4'd8;
			5'd11:   w = 4'd7;
			5'd12:   w = 4'd6;
			5'd13:   w = 4'd5;
			5'd14:   w = 4'd4;
			5'd15:   w = 4'd3;
			5'd16:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/vcdv_front.sv @@
// Front end: tracks the character position and classifies each incoming item.
`default_nettype none

module vcdv_front import vcdv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire vcdv_in_t    in_data,
	input  wire logic [7:0]  first_char,
	input  wire vcdv_qstat_t qstat,
	output logic             push,
	output vcdv_ent_t        push_data
);

	logic [4:0] pos_q;
	logic [4:0] pos_eff;
	logic       active;
	logic       accept;
	logic [4:0] tl;
	logic [3:0] wt;
	logic [7:0] prod_full;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;
	assign pos_eff  = in_data.start_req ? 5'd0 : pos_q;
	assign active   = pos_eff < 5'(VCDV_VIN_LEN);
	assign push     = accept && active;

	assign tl        = vcdv_translit(in_data.char_code);
	assign wt        = vcdv_weight(pos_eff);
	assign prod_full = 8'(tl[3:0]) * 8'(wt);

	always_comb begin
		push_data.first     = pos_eff == 5'd0;
		push_data.bad_first = (pos_eff == 5'd0) && (in_data.char_code != first_char);
		push_data.bad_char  = tl[4];
		push_data.prod      = prod_full[6:0];
		push_data.is_check  = pos_eff == 5'(VCDV_CHECK_POS);
		push_data.is_last   = pos_eff == 5'(VCDV_VIN_LEN - 1);
		push_data.char_code = in_data.char_code;
	end

	// Bytes past the end are dropped and leave the position idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
		end else if (push) begin
			pos_q <= pos_eff + 5'd1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/vcdv_queue.sv @@
// Short queue of classified items between front and back.
`default_nettype none

module vcdv_queue import vcdv_pkg::*; #(
	parameter int unsigned Depth = VCDV_QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire vcdv_ent_t push_data,
	input  wire logic      pop,
	output vcdv_ent_t      pop_data,
	output vcdv_qstat_t    qstat
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	vcdv_ent_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign qstat.full  = cnt_q == CntW'(Depth);
	assign qstat.empty = cnt_q == '0;
	assign pop_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/vcdv_back.sv @@
// Back end: accumulates the mod-11 sum and error state and issues the result.
`default_nettype none

module vcdv_back import vcdv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vcdv_ent_t   ent,
	input  wire vcdv_qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output vcdv_out_t        out_data
);

	logic [3:0]  sum_q;
	logic [1:0]  err_q;
	logic [7:0]  stored_q;
	logic        out_valid_q;
	vcdv_out_t   out_q;

	logic        out_free;
	logic [3:0]  base_sum;
	logic [1:0]  base_err;
	logic [6:0]  total;
	logic [14:0] quot_full;
	logic [3:0]  quot;
	logic [6:0]  rem_full;
	logic [3:0]  sum_nxt;
	logic [1:0]  err_nxt;
	logic [7:0]  stored_nxt;
	logic [7:0]  check;
	logic [1:0]  stat;
	vcdv_out_t   res;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = !qstat.empty && (!ent.is_last || out_free);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A new VIN starts from a clean sum and error.
	assign base_sum = ent.first ? 4'd0 : sum_q;
	assign base_err = ent.first ? ST_OK : err_q;

	// Reduce mod 11 by a reciprocal multiply; total never exceeds 100.
	assign total     = 7'(base_sum) + ent.prod;
	assign quot_full = 15'(total) * 15'(VCDV_RECIP);
	assign quot      = quot_full[14:VCDV_RECIP_SHIFT];
	assign rem_full  = total - 7'(quot) * 7'(VCDV_MODULUS);
	assign sum_nxt   = rem_full[3:0];

	always_comb begin
		err_nxt = base_err;
		if (ent.bad_first && err_nxt == ST_OK) begin
			err_nxt = ST_BAD_FIRST;
		end
		if (ent.bad_char && err_nxt == ST_OK) begin
			err_nxt = ST_BAD_CHAR;
		end
	end

	assign stored_nxt = ent.is_check ? ent.char_code : stored_q;
	assign check = (sum_nxt == 4'(VCDV_MODULUS - 1)) ? VCDV_CHECK_X
		: VCDV_DIGIT_ZERO + 8'(sum_nxt);

	always_comb begin
		stat = err_nxt;
		if (stat == ST_OK && check != stored_nxt) begin
			stat = ST_MISMATCH;
		end
		res.valid_res      = stat == ST_OK;
		res.status         = stat;
		res.expected_check = (stat == ST_BAD_FIRST || stat == ST_BAD_CHAR) ? 8'd0 : check;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= 4'd0;
			err_q       <= ST_OK;
			stored_q    <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				sum_q    <= sum_nxt;
				err_q    <= err_nxt;
				stored_q <= stored_nxt;
			end
			if (pop && ent.is_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result while stalled; load only on the last character.
	always_ff @(posedge clk) begin
		if (pop && ent.is_last) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/vin_check_digit_validator_core.sv @@
// VIN check digit validator: takes 17 ASCII characters, gives one verdict.
// Throughput: one character per cycle while in_stall is low.
// Output: the 17th character is written into the queue on the edge that takes it;
// out_valid rises once the back end pops it and registers the verdict.
// Reset: clears position, sum, error, queue and output valid; the region letter becomes 'L'.
`default_nettype none

`include "assert_macros.svh"

module vin_check_digit_validator_core import vcdv_pkg::*; #(
	parameter int unsigned QueueDepth = VCDV_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire vcdv_in_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output vcdv_out_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic [7:0]  first_char_q;
	logic        push;
	logic        pop;
	vcdv_ent_t   push_data;
	vcdv_ent_t   pop_data;
	vcdv_qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_char_q <= VCDV_FIRST_CHAR_RST;
		end else if (cfg_we) begin
			first_char_q <= cfg_wdata;
		end
	end

	vcdv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.first_char (first_char_q),
		.qstat      (qstat),
		.push       (push),
		.push_data  (push_data)
	);

	vcdv_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	vcdv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent       (pop_data),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`VCDV_ASSERT(a_valid_res_matches, clk, arst_n, out_valid |-> (out_data.valid_res == (out_data.status == ST_OK)), "valid_res disagrees with status")
	`VCDV_ASSERT(a_no_check_on_error, clk, arst_n, (out_valid && (out_data.status == ST_BAD_FIRST || out_data.status == ST_BAD_CHAR)) |-> (out_data.expected_check == 8'd0), "check character given on error")
	`VCDV_NEVER(a_queue_state, clk, arst_n, qstat.full && qstat.empty, "queue full and empty at once")
	`VCDV_NEVER(a_pop_from_empty, clk, arst_n, pop && qstat.empty, "pop from empty queue")

endmodule

`default_nettype wire
